/* sv/qamm_pkg.sv */
package qamm_pkg;

  // Field widths
  localparam int STICK_W = 13;
  localparam int CORR_W  = 14;
  localparam int DUTY_W  = 13;
  localparam int SUM_W   = 17;
  localparam int MOTORS  = 4;

  // Stick thresholds in Q1.12
  localparam logic [STICK_W-1:0] LOW_LIMIT          = 13'd204;
  localparam logic [STICK_W-1:0] CENTRE_MIN         = 13'd1844;
  localparam logic [STICK_W-1:0] CENTRE_MAX         = 13'd2252;
  localparam logic [STICK_W-1:0] RIGHT_MIN          = 13'd3892;
  localparam logic [STICK_W-1:0] THROTTLE_CAP_ABOVE = 13'd3276;
  localparam logic [STICK_W-1:0] THROTTLE_CAP       = 13'd3277;

  // Duty limits in Q1.12
  localparam logic [DUTY_W-1:0] DUTY_FLOOR = 13'd410;
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 13'd4096;
  localparam logic [DUTY_W-1:0] IDLE_DUTY  = 13'd410;
  localparam logic [DUTY_W-1:0] DUTY_OFF   = 13'd0;

  // Frame layout register codes
  localparam logic [1:0] LAYOUT_NONE  = 2'd0;
  localparam logic [1:0] LAYOUT_CROSS = 2'd1;
  localparam logic [1:0] LAYOUT_PLUS  = 2'd2;

  // Reported arming codes
  localparam logic [1:0] ARM_CODE_IDLE     = 2'd0;
  localparam logic [1:0] ARM_CODE_LOW_LEFT = 2'd1;
  localparam logic [1:0] ARM_CODE_ARMED    = 2'd2;
  localparam logic [1:0] ARM_CODE_DISARM   = 2'd3;

  // Arming machine
  typedef enum logic [3:0] {
    ARM_IDLE     = 4'b0001,
    ARM_LOW_LEFT = 4'b0010,
    ARM_ARMED    = 4'b0100,
    ARM_DISARM   = 4'b1000
  } arm_state_t;

  typedef logic [MOTORS-1:0][DUTY_W-1:0] duties_t;

  // One control tick
  typedef struct packed {
    logic [STICK_W-1:0]       throttle_stick;
    logic [STICK_W-1:0]       yaw_stick;
    logic signed [CORR_W-1:0] pitch_correction;
    logic signed [CORR_W-1:0] roll_correction;
    logic signed [CORR_W-1:0] yaw_correction;
  } tick_t;

  // Outcome of one tick
  typedef struct packed {
    duties_t    duties;
    logic       written;
    arm_state_t arm;
  } tick_result_t;

  // Saturate a mixed sum to the duty range
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SUM_W-1:0] d);
    logic [DUTY_W-1:0] res;
    if (d > $signed({4'b0, DUTY_FULL})) begin
      res = DUTY_FULL;
    end else if (d < $signed({4'b0, DUTY_FLOOR})) begin
      res = DUTY_FLOOR;
    end else begin
      res = d[DUTY_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [1:0] arm_code(input arm_state_t s);
    logic [1:0] code;
    case (s)
      ARM_IDLE:     code = ARM_CODE_IDLE;
      ARM_LOW_LEFT: code = ARM_CODE_LOW_LEFT;
      ARM_ARMED:    code = ARM_CODE_ARMED;
      ARM_DISARM:   code = ARM_CODE_DISARM;
      default:      code = ARM_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* sv/qamm_tick.sv */
module qamm_tick (
  input  qamm_pkg::tick_t        tick,
  input  logic [1:0]             layout,
  input  qamm_pkg::arm_state_t   arm,
  input  qamm_pkg::duties_t      duties,
  output qamm_pkg::tick_result_t result
);

  logic thr_low;
  logic yaw_low;
  logic yaw_centre;
  logic yaw_right;
  logic mix_on;
  logic signed [qamm_pkg::SUM_W-1:0] t;
  logic signed [qamm_pkg::SUM_W-1:0] p;
  logic signed [qamm_pkg::SUM_W-1:0] r;
  logic signed [qamm_pkg::SUM_W-1:0] y;
  logic signed [qamm_pkg::SUM_W-1:0] mix [qamm_pkg::MOTORS];

  // Decode stick positions
  assign thr_low    = tick.throttle_stick <= qamm_pkg::LOW_LIMIT;
  assign yaw_low    = tick.yaw_stick <= qamm_pkg::LOW_LIMIT;
  assign yaw_centre = (tick.yaw_stick >= qamm_pkg::CENTRE_MIN) &&
                      (tick.yaw_stick <= qamm_pkg::CENTRE_MAX);
  assign yaw_right  = tick.yaw_stick >= qamm_pkg::RIGHT_MIN;
  assign mix_on     = (layout == qamm_pkg::LAYOUT_CROSS) || (layout == qamm_pkg::LAYOUT_PLUS);

  // Cap throttle and widen the corrections
  assign t = (tick.throttle_stick > qamm_pkg::THROTTLE_CAP_ABOVE) ?
             $signed({4'b0, qamm_pkg::THROTTLE_CAP}) :
             $signed({4'b0, tick.throttle_stick});
  assign p = qamm_pkg::SUM_W'(tick.pitch_correction);
  assign r = qamm_pkg::SUM_W'(tick.roll_correction);
  assign y = qamm_pkg::SUM_W'(tick.yaw_correction);

  // Mix per frame layout
  always_comb begin
    if (layout == qamm_pkg::LAYOUT_CROSS) begin
      mix[0] = t - p + r - y;
      mix[1] = t + p + r + y;
      mix[2] = t + p - r - y;
      mix[3] = t - p - r + y;
    end else begin
      mix[0] = t - p - y;
      mix[1] = t + r + y;
      mix[2] = t + p - y;
      mix[3] = t - r + y;
    end
  end

  // Step the arming machine in tick order
  always_comb begin
    qamm_pkg::arm_state_t s;
    qamm_pkg::duties_t    d;
    logic                 w;
    s = arm;
    d = duties;
    w = 1'b0;
    if (thr_low && yaw_low) begin
      s = qamm_pkg::ARM_LOW_LEFT;
    end
    if (s == qamm_pkg::ARM_LOW_LEFT && thr_low && yaw_centre) begin
      s = qamm_pkg::ARM_ARMED;
      for (int i = 0; i < qamm_pkg::MOTORS; i++) d[i] = qamm_pkg::IDLE_DUTY;
      w = 1'b1;
    end
    if (s == qamm_pkg::ARM_ARMED && mix_on) begin
      for (int i = 0; i < qamm_pkg::MOTORS; i++) d[i] = qamm_pkg::clamp_duty(mix[i]);
      w = 1'b1;
    end
    if (s == qamm_pkg::ARM_ARMED && thr_low && yaw_right) begin
      s = qamm_pkg::ARM_DISARM;
    end
    if (s == qamm_pkg::ARM_DISARM && thr_low && yaw_centre) begin
      s = qamm_pkg::ARM_IDLE;
      for (int i = 0; i < qamm_pkg::MOTORS; i++) d[i] = qamm_pkg::DUTY_OFF;
      w = 1'b1;
    end
    result.duties  = d;
    result.written = w;
    result.arm     = s;
  end

endmodule

/* sv/quad_arming_and_motor_mixer.sv */
// Stick arming machine and four-motor mixer. One control tick is taken per
// clock; each produces exactly one result, passing the input register and
// then the result register, and a full tick rate is sustained as long as the
// result side keeps up. The arming state and the four held duties are
// updated as a tick moves from the input register into the result register,
// so the next tick sees them at once. frame_layout is written through the
// configuration channel, which is always ready; write it only while idle.
module quad_arming_and_motor_mixer (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             frame_layout,
  // Tick input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [qamm_pkg::STICK_W-1:0]           throttle_stick,
  input  logic [qamm_pkg::STICK_W-1:0]           yaw_stick,
  input  logic signed [qamm_pkg::CORR_W-1:0]     pitch_correction,
  input  logic signed [qamm_pkg::CORR_W-1:0]     roll_correction,
  input  logic signed [qamm_pkg::CORR_W-1:0]     yaw_correction,
  // Result output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [qamm_pkg::DUTY_W-1:0]            motor1_duty,
  output logic [qamm_pkg::DUTY_W-1:0]            motor2_duty,
  output logic [qamm_pkg::DUTY_W-1:0]            motor3_duty,
  output logic [qamm_pkg::DUTY_W-1:0]            motor4_duty,
  output logic                                   motors_written,
  output logic [1:0]                             arm_state
);

  logic                   layout;
  logic [1:0]             layout_reg;
  logic                   tick_valid;
  qamm_pkg::tick_t        tick;
  qamm_pkg::arm_state_t   arm;
  qamm_pkg::duties_t      duties;
  qamm_pkg::tick_result_t result_next;
  logic                   out_free;
  logic                   advance;

  assign layout    = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;

  // Hold the frame layout register
  always_ff @(posedge clk) begin
    if (rst) begin
      layout_reg <= qamm_pkg::LAYOUT_CROSS;
    end else if (layout) begin
      layout_reg <= frame_layout;
    end
  end

  // Handshake: advance a tick whenever the result register is free
  assign out_free = !out_valid || !out_stall;
  assign advance  = tick_valid && out_free;
  assign in_stall = tick_valid && !out_free;

  // Capture an input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      tick.throttle_stick   <= throttle_stick;
      tick.yaw_stick        <= yaw_stick;
      tick.pitch_correction <= pitch_correction;
      tick.roll_correction  <= roll_correction;
      tick.yaw_correction   <= yaw_correction;
    end
  end

  qamm_tick u_tick (
    .tick   (tick),
    .layout (layout_reg),
    .arm    (arm),
    .duties (duties),
    .result (result_next)
  );

  // Update arming state and held duties as a tick retires
  always_ff @(posedge clk) begin
    if (rst) begin
      arm    <= qamm_pkg::ARM_IDLE;
      duties <= '0;
    end else if (advance) begin
      arm    <= result_next.arm;
      duties <= result_next.duties;
    end
  end

  // Drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor1_duty    <= result_next.duties[0];
      motor2_duty    <= result_next.duties[1];
      motor3_duty    <= result_next.duties[2];
      motor4_duty    <= result_next.duties[3];
      motors_written <= result_next.written;
      arm_state      <= qamm_pkg::arm_code(result_next.arm);
    end
  end

endmodule
